// ===== design/lfu_key_tracker_core_macros.svh =====
// Assertion macros for the LFU key tracker checker.
// No dependencies; included by the checker file.
`ifndef LFU_KEY_TRACKER_CORE_MACROS_SVH
`define LFU_KEY_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, masked during reset
`define LKT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define LKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lkt_pkg.sv =====
// Shared types and constants for the LFU key tracker.
// No dependencies.
package lkt_pkg;

    localparam int ENTRIES    = 64;
    localparam int TAG_BITS   = 64;
    localparam int COUNT_BITS = 32;
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);
    localparam int CAP_BITS   = 7;

    localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(64);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NOTFOUND = 1'b1;

    // One table entry
    typedef struct packed {
        logic                  valid;
        logic [TAG_BITS-1:0]   tag;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic                  match_en;
        logic                  upd_en;
        logic [TAG_BITS-1:0]   tag;
        logic [COUNT_BITS-1:0] cnt;
    } ctl_t;

endpackage

// ===== design/lkt_cell.sv =====
// One slot of the eviction-ordered entry chain.
// Depends on lkt_pkg.
module lkt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  lkt_pkg::ctl_t ctl,
    input  logic          past,
    input  lkt_pkg::entry_t right_ent,
    input  logic          right_le,
    input  lkt_pkg::entry_t left_comp,
    input  logic          left_a,
    output lkt_pkg::entry_t ent,
    output logic          le,
    output lkt_pkg::entry_t comp,
    output logic          a,
    output logic          hit
);
    import lkt_pkg::*;

    logic                  valid_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  hit_reg;
    entry_t                ins;
    entry_t                ent_next;

    assign ent = '{valid: valid_reg, tag: tag_reg, count: count_reg};
    assign hit = hit_reg;

    // Entry sits at or before the insert point
    assign le = valid_reg && (count_reg <= ctl.cnt);

    // Close the gap left by the removed entry
    assign comp = past ? right_ent : ent;
    assign a    = past ? right_le : le;

    // Insert new entry after everything with count not above it
    assign ins = '{valid: 1'b1, tag: ctl.tag, count: ctl.cnt};
    always_comb
    begin
        if (a)
            ent_next = comp;
        else if (left_a)
            ent_next = ins;
        else
            ent_next = left_comp;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.match_en)
                hit_reg <= valid_reg && (tag_reg == ctl.tag);
            if (ctl.upd_en)
                valid_reg <= ent_next.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (ctl.upd_en)
        begin
            tag_reg   <= ent_next.tag;
            count_reg <= ent_next.count;
        end
    end

endmodule

// ===== design/lfu_key_tracker_core.sv =====
// Top level of the LFU key tracker: sequencer, output register, cell chain.
// Depends on lkt_pkg and lkt_cell.
// An LFU table of up to 64 keys, kept as a chain of cells in eviction order:
// smallest count first, and among equal counts the least recently touched
// first, so the victim is always the head cell. The accept cycle of a request
// compares the key against every cell in parallel; the update state then bumps
// a hit or inserts a missed put, shifting cells by at most one place. The
// update waits while a previous response is still held on the output.
// No clearing pass after reset; configuration writes are taken at any time.
module lfu_key_tracker_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [63:0]                     key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            status,
    output logic                            evicted,
    output logic [63:0]                     evicted_key,
    output logic [31:0]                     access_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lkt_pkg::CAP_BITS-1:0]    capacity
);
    import lkt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic                  op_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [CAP_BITS-1:0]   cap_reg;
    logic [OCC_BITS-1:0]   occ_reg;
    logic                  out_valid_reg;
    logic                  status_reg;
    logic                  evicted_reg;
    logic [63:0]           evicted_key_reg;
    logic [31:0]           access_count_reg;

    ctl_t                  ctl;
    entry_t                ent_arr  [ENTRIES];
    entry_t                comp_arr [ENTRIES];
    logic [ENTRIES-1:0]    le_vec, a_vec, hit_vec, past_vec;

    logic                  accept, fire, any_hit, evict_now, do_upd;
    logic [COUNT_BITS-1:0] hcnt, new_cnt;
    logic [OCC_BITS:0]     cap_eff;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign fire      = (state_reg == S_UPD) && (!out_valid_reg || out_ready);

    // Capacity clamped to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = (OCC_BITS + 1)'(1);
        else if ((OCC_BITS + 8)'(cap_reg) > (OCC_BITS + 8)'(ENTRIES))
            cap_eff = (OCC_BITS + 1)'(ENTRIES);
        else
            cap_eff = (OCC_BITS + 1)'(cap_reg);
    end

    // Count of the hit entry (one-hot select)
    always_comb
    begin
        hcnt = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (hit_vec[i])
                hcnt = hcnt | ent_arr[i].count;
    end

    assign any_hit   = |hit_vec;
    assign new_cnt   = any_hit ? ((hcnt == COUNT_MAX) ? hcnt : hcnt + 1'b1)
                               : COUNT_BITS'(1);
    assign evict_now = !any_hit && (op_reg == OP_PUT) &&
                       ((OCC_BITS + 1)'(occ_reg) >= cap_eff);
    assign do_upd    = fire && (any_hit || (op_reg == OP_PUT));

    // Broadcast controls
    always_comb
    begin
        ctl.match_en = accept;
        ctl.upd_en   = do_upd;
        ctl.tag      = (state_reg == S_IDLE) ? key[TAG_BITS-1:0] : tag_reg;
        ctl.cnt      = new_cnt;
    end

    // Cell chain
    for (genvar j = 0; j < ENTRIES; j++)
    begin : g_cell
        entry_t r_ent, l_comp;
        logic   r_le, l_a;

        assign past_vec[j] = evict_now || (|hit_vec[j:0]);

        if (j == ENTRIES - 1)
        begin : g_last
            assign r_ent = '0;
            assign r_le  = 1'b0;
        end
        else
        begin : g_mid
            assign r_ent = ent_arr[j+1];
            assign r_le  = le_vec[j+1];
        end

        if (j == 0)
        begin : g_head
            assign l_comp = '0;
            assign l_a    = 1'b1;
        end
        else
        begin : g_tail
            assign l_comp = comp_arr[j-1];
            assign l_a    = a_vec[j-1];
        end

        lkt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .past      (past_vec[j]),
            .right_ent (r_ent),
            .right_le  (r_le),
            .left_comp (l_comp),
            .left_a    (l_a),
            .ent       (ent_arr[j]),
            .le        (le_vec[j]),
            .comp      (comp_arr[j]),
            .a         (a_vec[j]),
            .hit       (hit_vec[j])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_UPD;
            S_UPD:   if (fire)   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                cap_reg <= capacity;
            if (do_upd && !any_hit && !evict_now)
                occ_reg <= occ_reg + 1'b1;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Request and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            tag_reg <= key[TAG_BITS-1:0];
        end
        if (fire)
        begin
            status_reg       <= (!any_hit && (op_reg == OP_GET)) ? ST_NOTFOUND : ST_OK;
            evicted_reg      <= evict_now;
            evicted_key_reg  <= evict_now ? 64'(ent_arr[0].tag) : 64'd0;
            access_count_reg <= (any_hit || (op_reg == OP_PUT)) ? 32'(new_cnt) : 32'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign evicted      = evicted_reg;
    assign evicted_key  = evicted_key_reg;
    assign access_count = access_count_reg;

endmodule

// ===== design/lkt_checker.sv =====
// Port-level checks for the LFU key tracker, bound to the top level.
// Depends on lkt_pkg and lfu_key_tracker_core_macros.svh.
`include "lfu_key_tracker_core_macros.svh"

module lkt_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            status,
    input  logic                            evicted,
    input  logic [63:0]                     evicted_key,
    input  logic [31:0]                     access_count
);
    import lkt_pkg::*;

    // A held response stays valid and keeps its count
    `LKT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(access_count), "response changed while stalled")

    // A miss on get carries no count and no eviction
    `LKT_ASSERT_NOW(a_miss, out_valid && status == ST_NOTFOUND, access_count == 32'd0 && !evicted, "bad not-found response")

    // An eviction only comes with a fresh insert
    `LKT_ASSERT_NOW(a_evict, out_valid && evicted, status == ST_OK && access_count == 32'd1, "eviction without insert")

    // No eviction means no evicted key
    `LKT_ASSERT_NOW(a_nokey, out_valid && !evicted, evicted_key == 64'd0, "stray evicted key")

    // One request in flight at a time
    `LKT_ASSERT_NEXT(a_single, in_valid && in_ready, !in_ready, "second request taken too early")

endmodule

bind lfu_key_tracker_core lkt_checker u_lkt_checker (.*);
